@@ design/cau_pkg.sv @@
// shared types and constants of the complex arithmetic unit
`default_nettype none
package cau_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned THR_W          = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // control that rides along the divider stages
  typedef struct packed {
    logic valid;
    logic is_div;
    logic zero;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
    logic sat;
  } cau_ctrl_t;

endpackage
`default_nettype wire

@@ design/cau_mult.sv @@
// operand sums and the five product multipliers, two register stages
`default_nettype none
module cau_mult #(
  parameter int unsigned DW = cau_pkg::DATA_WIDTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  cau_pkg::req_e              op_i,
  input  wire logic signed [DW-1:0]  ar_i,
  input  wire logic signed [DW-1:0]  ai_i,
  input  wire logic signed [DW-1:0]  br_i,
  input  wire logic signed [DW-1:0]  bi_i,
  output logic                       valid_o,
  output cau_pkg::req_e              op_o,
  output logic signed [2*DW-1:0]     p_o,
  output logic signed [2*DW-1:0]     q_o,
  output logic signed [2*DW-1:0]     wr_o,
  output logic signed [2*DW-1:0]     wi_o,
  output logic signed [2*DW+1:0]     s_o,
  output logic signed [DW:0]         add_re_o,
  output logic signed [DW:0]         add_im_o
);
  import cau_pkg::*;

  logic                 va_q;
  req_e                 opa_q;
  logic signed [DW-1:0] ar_q, ai_q, br_q, bi_q;
  logic signed [DW:0]   sa_q, sb_q, sa_d, sb_d;
  logic signed [DW:0]   ad_re_q, ad_im_q, ad_re_d, ad_im_d;
  logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;

  assign ar_x = {ar_i[DW-1], ar_i};
  assign ai_x = {ai_i[DW-1], ai_i};
  assign br_x = {br_i[DW-1], br_i};
  assign bi_x = {bi_i[DW-1], bi_i};

  always_comb begin
    sa_d = ar_x + ai_x;
    // divide takes the conjugate of b
    sb_d = (op_i == OP_DIV) ? (br_x - bi_x) : (br_x + bi_x);
    if (op_i == OP_SUB) begin
      ad_re_d = ar_x - br_x;
      ad_im_d = ai_x - bi_x;
    end else begin
      ad_re_d = ar_x + br_x;
      ad_im_d = ai_x + bi_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q   <= op_i;
    ar_q    <= ar_i;
    ai_q    <= ai_i;
    br_q    <= br_i;
    bi_q    <= bi_i;
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    ad_re_q <= ad_re_d;
    ad_im_q <= ad_im_d;
    op_o     <= opa_q;
    p_o      <= ar_q * br_q;
    q_o      <= ai_q * bi_q;
    wr_o     <= br_q * br_q;
    wi_o     <= bi_q * bi_q;
    s_o      <= sa_q * sb_q;
    add_re_o <= ad_re_q;
    add_im_o <= ad_im_q;
  end

endmodule
`default_nettype wire

@@ design/cau_div_step.sv @@
// one restoring division step for both lanes, registered
`default_nettype none
module cau_div_step #(
  parameter int unsigned DW = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned QB = DW + 1
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  cau_pkg::cau_ctrl_t         ctrl_i,
  input  wire logic [2*DW-1:0]       w_i,
  input  wire logic [2*DW-1:0]       r_re_i,
  input  wire logic [2*DW-1:0]       r_im_i,
  input  wire logic [QB-1:0]         lo_re_i,
  input  wire logic [QB-1:0]         lo_im_i,
  input  wire logic [DW-1:0]         res_re_i,
  input  wire logic [DW-1:0]         res_im_i,
  output cau_pkg::cau_ctrl_t         ctrl_o,
  output logic [2*DW-1:0]            w_o,
  output logic [2*DW-1:0]            r_re_o,
  output logic [2*DW-1:0]            r_im_o,
  output logic [QB-1:0]              lo_re_o,
  output logic [QB-1:0]              lo_im_o,
  output logic [DW-1:0]              res_re_o,
  output logic [DW-1:0]              res_im_o
);
  import cau_pkg::*;

  localparam int unsigned WW = 2 * DW;

  logic [WW:0]   t_re, t_im, wx, df_re, df_im;
  logic          ge_re, ge_im;
  logic [WW-1:0] r_re_d, r_im_d;

  always_comb begin
    wx    = {1'b0, w_i};
    t_re  = {r_re_i, lo_re_i[QB-1]};
    t_im  = {r_im_i, lo_im_i[QB-1]};
    df_re = t_re - wx;
    df_im = t_im - wx;
    ge_re = (t_re >= wx);
    ge_im = (t_im >= wx);
    r_re_d = ge_re ? df_re[WW-1:0] : t_re[WW-1:0];
    r_im_d = ge_im ? df_im[WW-1:0] : t_im[WW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else begin
      ctrl_o <= ctrl_i;
    end
  end

  // numerator bits shift out at the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    w_o      <= w_i;
    r_re_o   <= r_re_d;
    r_im_o   <= r_im_d;
    lo_re_o  <= {lo_re_i[QB-2:0], ge_re};
    lo_im_o  <= {lo_im_i[QB-2:0], ge_im};
    res_re_o <= res_re_i;
    res_im_o <= res_im_i;
  end

endmodule
`default_nettype wire

@@ design/complex_arithmetic_unit.sv @@
// top level of the pipelined complex arithmetic unit
`default_nettype none
// Complex add, subtract, multiply and divide on signed fixed point operands
// (Q16.16 by default). A transaction is taken whenever start is high; busy
// is always low, so one transaction enters per cycle with no gaps. Every
// transaction gives exactly one result, shown for one cycle with res_valid_o
// high, in order. All operations pass through the same pipeline: two
// multiplier stages, three scaling stages, the bit-per-stage restoring
// divider (DATA_WIDTH + 1 stages) and a registered output stage. The
// receiver cannot stall the output. The user must write the divide threshold
// through cfg_we_i / cfg_wdata_i only while no transaction is in flight; the
// block itself does not enforce this. Status: 0 ok, 1 a part saturated,
// 2 divisor near zero (result zero).
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_im_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_im_i,
  input  wire                              cfg_we_i,
  input  wire logic [cau_pkg::THR_W-1:0]   cfg_wdata_i,
  output logic                             res_valid_o,
  output logic signed [DATA_WIDTH-1:0]     res_re_o,
  output logic signed [DATA_WIDTH-1:0]     res_im_o,
  output logic [1:0]                       status_o
);
  import cau_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned WW = 2 * DW;        // divisor and remainder width
  localparam int unsigned PW = 2 * DW + 2;    // full-precision signed width
  localparam int unsigned NW = PW + F;        // scaled numerator width
  localparam int unsigned QB = DW + 1;        // quotient bits produced
  localparam int unsigned CW = (WW > THR_W + F) ? WW : THR_W + F;

  localparam logic signed [PW-1:0] SMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [QB-1:0] QHALF = QB'(1) << (DW - 1);
  localparam logic [DW-1:0] RMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] RMIN  = {1'b1, {(DW-1){1'b0}}};

  // no backpressure anywhere in the pipe
  assign busy = 1'b0;

  // threshold register
  logic [THR_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stages 1-2: sums and products
  logic                 m_valid;
  req_e                 m_op;
  logic signed [WW-1:0] m_p, m_q, m_wr, m_wi;
  logic signed [PW-1:0] m_s;
  logic signed [DW:0]   m_add_re, m_add_im;

  cau_mult #(.DW(DW)) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start & ~busy),
    .op_i     (req_e'(req_type_i)),
    .ar_i     (a_re_i),
    .ai_i     (a_im_i),
    .br_i     (b_re_i),
    .bi_i     (b_im_i),
    .valid_o  (m_valid),
    .op_o     (m_op),
    .p_o      (m_p),
    .q_o      (m_q),
    .wr_o     (m_wr),
    .wi_o     (m_wi),
    .s_o      (m_s),
    .add_re_o (m_add_re),
    .add_im_o (m_add_im)
  );

  // stage 3: combine products into results, numerators and divisor
  logic signed [PW-1:0] pe, qe, d_re, d_im, nd_re_d, nd_im_d;
  logic signed [PW-1:0] nd_re_q, nd_im_q, n_re_q, n_im_q;
  logic [WW-1:0]        w3_q;
  logic                 v3_q, div3_q;

  always_comb begin
    pe   = {{2{m_p[WW-1]}}, m_p};
    qe   = {{2{m_q[WW-1]}}, m_q};
    d_re = pe - qe;
    d_im = m_s - pe - qe;
    case (m_op)
      OP_MUL: begin
        // arithmetic shift rounds toward minus infinity
        nd_re_d = d_re >>> F;
        nd_im_d = d_im >>> F;
      end
      default: begin
        nd_re_d = {{(PW-DW-1){m_add_re[DW]}}, m_add_re};
        nd_im_d = {{(PW-DW-1){m_add_im[DW]}}, m_add_im};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    div3_q  <= (m_op == OP_DIV);
    nd_re_q <= nd_re_d;
    nd_im_q <= nd_im_d;
    // conjugate numerators: re = p + q, im = s - p + q
    n_re_q  <= pe + qe;
    n_im_q  <= m_s - pe + qe;
    w3_q    <= $unsigned(m_wr) + $unsigned(m_wi);
  end

  // stage 4: saturate non-divide results, take magnitudes, test divisor
  logic           sat_re4, sat_im4, zero4;
  logic [DW-1:0]  r_re4, r_im4;
  logic [PW-1:0]  abs_re4, abs_im4;
  cau_ctrl_t      c4_q;
  logic [DW-1:0]  res_re4_q, res_im4_q;
  logic [NW-1:0]  num_re4_q, num_im4_q;
  logic [WW-1:0]  w4_q;

  always_comb begin
    sat_re4 = (nd_re_q > SMAX) || (nd_re_q < SMIN);
    sat_im4 = (nd_im_q > SMAX) || (nd_im_q < SMIN);
    r_re4 = (nd_re_q > SMAX) ? RMAX : (nd_re_q < SMIN) ? RMIN : nd_re_q[DW-1:0];
    r_im4 = (nd_im_q > SMAX) ? RMAX : (nd_im_q < SMIN) ? RMIN : nd_im_q[DW-1:0];
    abs_re4 = n_re_q[PW-1] ? $unsigned(-n_re_q) : $unsigned(n_re_q);
    abs_im4 = n_im_q[PW-1] ? $unsigned(-n_im_q) : $unsigned(n_im_q);
    zero4 = (CW'(w3_q) <= (CW'(thr_q) << F));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
    end else begin
      c4_q.valid  <= v3_q;
      c4_q.is_div <= div3_q;
      c4_q.zero   <= div3_q & zero4;
      c4_q.neg_re <= n_re_q[PW-1];
      c4_q.neg_im <= n_im_q[PW-1];
      c4_q.ovf_re <= 1'b0;
      c4_q.ovf_im <= 1'b0;
      c4_q.sat    <= sat_re4 | sat_im4;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re4_q <= r_re4;
    res_im4_q <= r_im4;
    num_re4_q <= NW'(abs_re4) << F;
    num_im4_q <= NW'(abs_im4) << F;
    w4_q      <= w3_q;
  end

  // stage 5: quotient overflow check and divider seed
  cau_ctrl_t      dc   [0:QB];
  logic [WW-1:0]  dw   [0:QB];
  logic [WW-1:0]  drr  [0:QB];
  logic [WW-1:0]  dri  [0:QB];
  logic [QB-1:0]  dlr  [0:QB];
  logic [QB-1:0]  dli  [0:QB];
  logic [DW-1:0]  dxr  [0:QB];
  logic [DW-1:0]  dxi  [0:QB];
  logic [NW-1:0]  hi_re5, hi_im5;
  cau_ctrl_t      c5_d;

  always_comb begin
    hi_re5 = num_re4_q >> QB;
    hi_im5 = num_im4_q >> QB;
    c5_d   = c4_q;
    // quotient needs more than QB bits: saturates regardless
    c5_d.ovf_re = (hi_re5 >= NW'(w4_q));
    c5_d.ovf_im = (hi_im5 >= NW'(w4_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc[0] <= '0;
    end else begin
      dc[0] <= c5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw[0]  <= w4_q;
    drr[0] <= WW'(hi_re5);
    dri[0] <= WW'(hi_im5);
    dlr[0] <= num_re4_q[QB-1:0];
    dli[0] <= num_im4_q[QB-1:0];
    dxr[0] <= res_re4_q;
    dxi[0] <= res_im4_q;
  end

  // divider: one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    cau_div_step #(.DW(DW), .QB(QB)) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (dc[g]),
      .w_i      (dw[g]),
      .r_re_i   (drr[g]),
      .r_im_i   (dri[g]),
      .lo_re_i  (dlr[g]),
      .lo_im_i  (dli[g]),
      .res_re_i (dxr[g]),
      .res_im_i (dxi[g]),
      .ctrl_o   (dc[g+1]),
      .w_o      (dw[g+1]),
      .r_re_o   (drr[g+1]),
      .r_im_o   (dri[g+1]),
      .lo_re_o  (dlr[g+1]),
      .lo_im_o  (dli[g+1]),
      .res_re_o (dxr[g+1]),
      .res_im_o (dxi[g+1])
    );
  end

  // output stage: apply sign, saturate quotients, pick the result
  cau_ctrl_t      cf;
  logic [QB-1:0]  qr, qi, nqr, nqi;
  logic           qsat_re, qsat_im;
  logic [DW-1:0]  out_re_d, out_im_d;
  status_e        st_d;

  logic           res_valid_q;
  logic [DW-1:0]  res_re_q, res_im_q;
  status_e        status_q;

  always_comb begin
    cf  = dc[QB];
    qr  = dlr[QB];
    qi  = dli[QB];
    nqr = -qr;
    nqi = -qi;
    // negative side reaches one step further than positive
    qsat_re = cf.ovf_re || (cf.neg_re ? (qr > QHALF) : (qr >= QHALF));
    qsat_im = cf.ovf_im || (cf.neg_im ? (qi > QHALF) : (qi >= QHALF));
    if (!cf.is_div) begin
      out_re_d = dxr[QB];
      out_im_d = dxi[QB];
      st_d     = cf.sat ? ST_SAT : ST_OK;
    end else if (cf.zero) begin
      out_re_d = '0;
      out_im_d = '0;
      st_d     = ST_DIV_ZERO;
    end else begin
      if (qsat_re) begin
        out_re_d = cf.neg_re ? RMIN : RMAX;
      end else begin
        out_re_d = cf.neg_re ? nqr[DW-1:0] : qr[DW-1:0];
      end
      if (qsat_im) begin
        out_im_d = cf.neg_im ? RMIN : RMAX;
      end else begin
        out_im_d = cf.neg_im ? nqi[DW-1:0] : qi[DW-1:0];
      end
      st_d = (qsat_re | qsat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= out_re_d;
    res_im_q <= out_im_d;
    status_q <= st_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_re_o    = $signed(res_re_q);
  assign res_im_o    = $signed(res_im_q);
  assign status_o    = status_q;

  // a refused divide always reports zero parts
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == ST_DIV_ZERO) |-> (res_re_q == '0 && res_im_q == '0))
    else $error("divide-by-zero result not zero");

  // a saturated result has at least one part at a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == ST_SAT) |->
      (res_re_q == RMAX || res_re_q == RMIN || res_im_q == RMAX || res_im_q == RMIN))
    else $error("saturation flagged without a clamped part");

  // near-zero marking only arises on divides
  a_zero_is_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cf.valid && cf.zero) |-> cf.is_div)
    else $error("near-zero flag on a non-divide transaction");

  // a result is registered out after its control reaches the end of the divider
  a_valid_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf.valid |=> res_valid_o)
    else $error("result strobe lost at output stage");

endmodule
`default_nettype wire
